### rtl/ssc_pkg.sv
package ssc_pkg;

  localparam int ADDR_W   = 5;
  localparam int REG_IX_W = 3;
  localparam int DATA_W   = 32;
  localparam int SUM_W    = 23;
  localparam int ROM_W    = 17;
  localparam int PROD_W   = 34;
  localparam int ACC_W    = 58;
  localparam int LO_W     = 12;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [REG_IX_W-1:0] {
    REG_EXC_G  = 3'd0,
    REG_INH_G  = 3'd1,
    REG_THR    = 3'd2,
    REG_EXC_RV = 3'd3,
    REG_INH_RV = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] exc_g;
    logic        [15:0] inh_g;
    logic signed [15:0] thr;
    logic signed [15:0] exc_rv;
    logic signed [15:0] inh_rv;
  } ssc_cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GE,
    OP_GI,
    OP_EL,
    OP_EH,
    OP_IL,
    OP_IH
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_FLUSH,
    ST_MUL_GE,
    ST_MUL_GI,
    ST_MUL_EL,
    ST_MUL_EH,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_FINISH
  } ssc_state_t;

  typedef struct packed {
    logic    accept;
    mul_op_t op;
    logic    load_out;
  } ssc_cmd_t;

  typedef struct packed {
    logic snap;
    logic a_last;
    logic b_last;
    logic out_free;
  } ssc_status_t;

  // Restoring long division, used only to build the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid table entry k of n, unsigned Q1.16.
  function automatic logic [ROM_W-1:0] sigmoid_entry(input int k, input int n);
    logic [63:0] num;
    logic [63:0] off;
    logic [63:0] ax;
    logic [63:0] b;
    logic [63:0] b2;
    logic [63:0] b3;
    logic [63:0] b4;
    logic [63:0] y;
    logic [63:0] den;
    logic [63:0] s;
    logic        neg;
    int          i;
    num = 64'(2 * k + 1) << 20;
    off = udiv64(num, 64'(n));
    if (off < (64'd1 << 20)) begin
      neg = 1'b1;
      ax  = (64'd1 << 20) - off;
    end else begin
      neg = 1'b0;
      ax  = off - (64'd1 << 20);
    end
    b  = ax << 8;
    b2 = (b * b) >> 30;
    b3 = (b2 * b) >> 30;
    b4 = (b3 * b) >> 30;
    y  = (64'd1 << 30) - b + b2 / 64'd2 - b3 / 64'd6 + b4 / 64'd24;
    for (i = 0; i < 6; i++) begin
      y = (y * y + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + y;
    s   = udiv64((64'd1 << 46) + (den >> 1), den);
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    if (neg) begin
      s = 64'd65536 - s;
    end
    return s[ROM_W-1:0];
  endfunction

endpackage

### rtl/ssc_regs.sv
module ssc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssc_pkg::DATA_W-1:0]  pwdata,
  output logic [ssc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssc_pkg::ssc_cfg_t           cfg
);
  import ssc_pkg::*;

  logic                wr_en;
  logic [REG_IX_W-1:0] reg_ix;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign reg_ix = paddr[REG_IX_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_ix)
        REG_EXC_G:  cfg.exc_g  <= pwdata[15:0];
        REG_INH_G:  cfg.inh_g  <= pwdata[15:0];
        REG_THR:    cfg.thr    <= pwdata[15:0];
        REG_EXC_RV: cfg.exc_rv <= pwdata[15:0];
        REG_INH_RV: cfg.inh_rv <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_ix)
      REG_EXC_G:  prdata = {16'b0, cfg.exc_g};
      REG_INH_G:  prdata = {16'b0, cfg.inh_g};
      REG_THR:    prdata = {16'b0, cfg.thr};
      REG_EXC_RV: prdata = {16'b0, cfg.exc_rv};
      REG_INH_RV: prdata = {16'b0, cfg.inh_rv};
      default:    prdata = '0;
    endcase
  end

endmodule

### rtl/ssc_ctrl.sv
module ssc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_stall,
  input  ssc_pkg::ssc_status_t status,
  output ssc_pkg::ssc_cmd_t    cmd
);
  import ssc_pkg::*;

  ssc_state_t state;
  ssc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd.accept   = 1'b0;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        // hold off new requests once a last one is in the pipe
        if (in_valid && in_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.snap) begin
          state_next = ST_MUL_GE;
        end
      end
      ST_MUL_GE: begin
        cmd.op     = OP_GE;
        state_next = ST_MUL_GI;
      end
      ST_MUL_GI: begin
        cmd.op     = OP_GI;
        state_next = ST_MUL_EL;
      end
      ST_MUL_EL: begin
        cmd.op     = OP_EL;
        state_next = ST_MUL_EH;
      end
      ST_MUL_EH: begin
        cmd.op     = OP_EH;
        state_next = ST_MUL_IL;
      end
      ST_MUL_IL: begin
        cmd.op     = OP_IL;
        state_next = ST_MUL_IH;
      end
      ST_MUL_IH: begin
        cmd.op     = OP_IH;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  a_flush_has_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (status.a_last || status.b_last))
    else $error("flush without a last request in flight");

  a_snap_in_flush: assert property (@(posedge clk) disable iff (rst)
    status.snap |-> (state == ST_FLUSH))
    else $error("snapshot outside flush");

  a_run_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == ST_RUN))
    else $error("controller did not return to run after result load");

endmodule

### rtl/ssc_dp.sv
module ssc_dp #(
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ssc_pkg::ssc_cfg_t    cfg,
  input  logic signed [15:0]   pre_voltage,
  input  logic                 pre_is_excitatory,
  input  logic                 neighbor_valid,
  input  logic signed [15:0]   own_voltage,
  input  logic                 target_coupled,
  input  logic                 last,
  input  ssc_pkg::ssc_cmd_t    cmd,
  output ssc_pkg::ssc_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   coupling_current
);
  import ssc_pkg::*;

  localparam int IDX_W = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
  localparam int SCL_W = 13 + IDX_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd524288);

  logic [ROM_W-1:0] rom [SIGMOID_ENTRIES];

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    assign rom[k] = sigmoid_entry(k, SIGMOID_ENTRIES);
  end

  // index computation
  logic signed [16:0] diff;
  logic signed [16:0] clamped;
  logic        [12:0] ofs;
  logic [SCL_W-1:0]   scaled;
  logic [IDX_W-1:0]   idx;

  always_comb begin
    diff = $signed({pre_voltage[15], pre_voltage}) - $signed({cfg.thr[15], cfg.thr});
    if (diff < -17'sd4096) begin
      clamped = -17'sd4096;
    end else if (diff > 17'sd4095) begin
      clamped = 17'sd4095;
    end else begin
      clamped = diff;
    end
    ofs    = 13'(clamped + 17'sd4096);
    scaled = SCL_W'(ofs) * SCL_W'(SIGMOID_ENTRIES);
    idx    = scaled[IDX_W+12:13];
  end

  // stage A
  logic               a_valid;
  logic [IDX_W-1:0]   a_idx;
  logic               a_nv;
  logic               a_exc;
  logic               a_last;
  logic signed [15:0] a_own;
  logic               a_cpl;
  // stage B
  logic               b_valid;
  logic [ROM_W-1:0]   rom_q;
  logic               b_nv;
  logic               b_exc;
  logic               b_last;
  logic signed [15:0] b_own;
  logic               b_cpl;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= cmd.accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_idx  <= idx;
    a_nv   <= neighbor_valid;
    a_exc  <= pre_is_excitatory;
    a_last <= last;
    a_own  <= own_voltage;
    a_cpl  <= target_coupled;
    rom_q  <= rom[a_idx];
    b_nv   <= a_nv;
    b_exc  <= a_exc;
    b_last <= a_last;
    b_own  <= a_own;
    b_cpl  <= a_cpl;
  end

  // accumulation
  logic [SUM_W-1:0] exc_sum;
  logic [SUM_W-1:0] inh_sum;
  logic [ROM_W-1:0] s_exc;
  logic [ROM_W-1:0] s_inh;
  logic [SUM_W:0]   exc_tot;
  logic [SUM_W:0]   inh_tot;
  logic [SUM_W-1:0] exc_sat;
  logic [SUM_W-1:0] inh_sat;
  logic             snap;

  always_comb begin
    s_exc   = (b_nv && b_exc) ? rom_q : '0;
    s_inh   = (b_nv && !b_exc) ? rom_q : '0;
    exc_tot = {1'b0, exc_sum} + (SUM_W+1)'(s_exc);
    inh_tot = {1'b0, inh_sum} + (SUM_W+1)'(s_inh);
    exc_sat = (exc_tot > {1'b0, SUM_MAX}) ? SUM_MAX : exc_tot[SUM_W-1:0];
    inh_sat = (inh_tot > {1'b0, SUM_MAX}) ? SUM_MAX : inh_tot[SUM_W-1:0];
    snap    = b_valid && b_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exc_sum <= '0;
      inh_sum <= '0;
    end else if (b_valid) begin
      // clear for the next target once the last request lands
      exc_sum <= b_last ? '0 : exc_sat;
      inh_sum <= b_last ? '0 : inh_sat;
    end
  end

  logic [SUM_W-1:0]   snap_e;
  logic [SUM_W-1:0]   snap_i;
  logic signed [16:0] de;
  logic signed [16:0] di;
  logic               snap_cpl;

  always_ff @(posedge clk) begin
    if (snap) begin
      snap_e   <= exc_sat;
      snap_i   <= inh_sat;
      de       <= $signed({cfg.exc_rv[15], cfg.exc_rv}) - $signed({b_own[15], b_own});
      di       <= $signed({cfg.inh_rv[15], cfg.inh_rv}) - $signed({b_own[15], b_own});
      snap_cpl <= b_cpl;
    end
  end

  // shared multiplier
  logic signed [PROD_W-1:0]    mul_a;
  logic signed [16:0]          mul_b;
  logic signed [PROD_W+16:0]   prod;
  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [ACC_W-1:0]     addend;
  logic signed [PROD_W-1:0]    pe;
  logic signed [PROD_W-1:0]    pi;
  logic signed [ACC_W-1:0]     acc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_GE: begin
        mul_a = $signed({18'b0, cfg.exc_g});
        mul_b = de;
      end
      OP_GI: begin
        mul_a = $signed({18'b0, cfg.inh_g});
        mul_b = di;
      end
      OP_EL: begin
        mul_a = pe;
        mul_b = $signed({5'b0, snap_e[LO_W-1:0]});
      end
      OP_EH: begin
        mul_a = pe;
        mul_b = $signed({6'b0, snap_e[SUM_W-1:LO_W]});
      end
      OP_IL: begin
        mul_a = pi;
        mul_b = $signed({5'b0, snap_i[LO_W-1:0]});
      end
      OP_IH: begin
        mul_a = pi;
        mul_b = $signed({6'b0, snap_i[SUM_W-1:LO_W]});
      end
      OP_NONE: ;
      default: ;
    endcase
    prod     = mul_a * mul_b;
    prod_ext = ACC_W'(prod);
    addend   = (cmd.op == OP_EH || cmd.op == OP_IH) ? (prod_ext <<< LO_W) : prod_ext;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_GE:   pe  <= prod[PROD_W-1:0];
      OP_GI:   pi  <= prod[PROD_W-1:0];
      OP_EL:   acc <= addend;
      OP_EH:   acc <= acc + addend;
      OP_IL:   acc <= acc + addend;
      OP_IH:   acc <= acc + addend;
      OP_NONE: ;
      default: ;
    endcase
  end

  // round half up to Q.16, then saturate
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shr;
  logic signed [31:0]      result;

  always_comb begin
    rnd = acc + RND_HALF;
    shr = rnd >>> 20;
    if (!snap_cpl) begin
      result = '0;
    end else if (shr > SAT_MAX) begin
      result = 32'sh7FFF_FFFF;
    end else if (shr < SAT_MIN) begin
      result = 32'sh8000_0000;
    end else begin
      result = 32'(shr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      coupling_current <= result;
    end
  end

  always_comb begin
    status.snap     = snap;
    status.a_last   = a_valid && a_last;
    status.b_last   = b_valid && b_last;
    status.out_free = !out_valid || !out_stall;
  end

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    snap |=> (exc_sum == '0 && inh_sum == '0))
    else $error("accumulators not cleared after last request");

  a_uncoupled_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !snap_cpl) |=> (coupling_current == '0))
    else $error("uncoupled target produced a nonzero current");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending one");

endmodule

### rtl/sigmoid_synaptic_coupling_core.sv
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  pre_voltage, pre_is_excitatory, neighbor_valid,
//                                    own_voltage, target_coupled, last
// out      out  out_valid/out_stall  coupling_current
// cfg      in   APB psel/penable     paddr, pwdata, prdata, pready
//
// Non-last requests are taken one per cycle; after the last request of a target, the
// two-stage sigmoid lookup flushes and six passes go through the shared multiplier.
// Reset (rst, synchronous) clears the config registers, input sums, pipe valids and the FSM.
// Input stalls from the last request of a target until its result is loaded; a result
// waiting on out_stall does not stall input except when the next result is ready to load.
module sigmoid_synaptic_coupling_core #(
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssc_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssc_pkg::DATA_W-1:0]  pwdata,
  output logic [ssc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          pre_voltage,
  input  logic                        pre_is_excitatory,
  input  logic                        neighbor_valid,
  input  logic signed [15:0]          own_voltage,
  input  logic                        target_coupled,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          coupling_current
);
  import ssc_pkg::*;

  ssc_cfg_t    cfg;
  ssc_cmd_t    cmd;
  ssc_status_t status;

  ssc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssc_dp #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .pre_voltage       (pre_voltage),
    .pre_is_excitatory (pre_is_excitatory),
    .neighbor_valid    (neighbor_valid),
    .own_voltage       (own_voltage),
    .target_coupled    (target_coupled),
    .last              (last),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .coupling_current  (coupling_current)
  );

endmodule
